/* rtl/flood_packet_dedup_cache_core_defines.svh */
// Assertion macros for the flood packet dedup cache.
`ifndef FLOOD_PACKET_DEDUP_CACHE_CORE_DEFINES_SVH
`define FLOOD_PACKET_DEDUP_CACHE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FPDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpdc check failed");
`define FPDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpdc check failed");
`else
`define FPDC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FPDC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/fpdc_pkg.sv */
// Types and constants of the flood packet dedup cache.
`default_nettype none

package fpdc_pkg;

   localparam int unsigned HASH_WIDTH = 64;
   localparam int unsigned TIME_WIDTH = 32;
   localparam int unsigned OCC_WIDTH  = 6;

   localparam logic [TIME_WIDTH-1:0] EXPIRE_RESET = 32'd60000;

   typedef struct packed {
      logic [HASH_WIDTH-1:0] packet_hash;
      logic [TIME_WIDTH-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic                 is_duplicate;
      logic                 evicted_oldest;
      logic [OCC_WIDTH-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic issue_left;
      logic eval_busy;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* rtl/fpdc_ctrl.sv */
// Sequencer: accept, expiry sweep over the ring, commit of the result.
`default_nettype none

module fpdc_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  fpdc_pkg::status_type status,
   output fpdc_pkg::cmd_type   cmd
);
   import fpdc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SWEEP  = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.issue = status.issue_left;
            if (!status.issue_left && !status.eval_busy) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/fpdc_datapath.sv */
// Entry memory, ring pointers, expiry/match evaluation and result register.
`default_nettype none

module fpdc_datapath #(
   parameter int unsigned DEPTH     = 32,
   parameter int unsigned HASH_BITS = 64
) (
   input  wire                  clock,
   input  wire                  reset,
   input  fpdc_pkg::cmd_type    cmd,
   output fpdc_pkg::status_type status,
   input  fpdc_pkg::req_type    req_word,
   input  wire                  csr_valid,
   input  wire [31:0]           csr_data,
   input  wire                  rsp_stall,
   output logic                 rsp_valid,
   output fpdc_pkg::rsp_type    rsp_word
);
   import fpdc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   logic [HASH_BITS-1:0]  hash_mem [DEPTH];
   logic [TIME_WIDTH-1:0] time_mem [DEPTH];

   logic [TIME_WIDTH-1:0] expire_ff;
   logic [PTR_W-1:0]      oldest_ff, oldest_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [HASH_BITS-1:0]  key_ff;
   logic [TIME_WIDTH-1:0] now_ff;
   logic [PTR_W-1:0]      rd_slot_ff, rd_slot_in;
   logic [PTR_W-1:0]      wr_slot_ff, wr_slot_in;
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0]      kept_ff, kept_in;
   logic                  dup_ff, dup_in;
   logic                  eval_ff;
   logic [HASH_BITS-1:0]  rd_hash_ff;
   logic [TIME_WIDTH-1:0] rd_time_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic [TIME_WIDTH-1:0] age;
   logic                  keep;
   logic                  full;
   logic                  mem_we;
   logic [HASH_BITS-1:0]  mem_whash;
   logic [TIME_WIDTH-1:0] mem_wtime;

   function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == LAST_SLOT) ? '0 : p + 1'b1;
      return r;
   endfunction

   always_comb begin
      age  = now_ff - rd_time_ff;
      keep = eval_ff && (age <= expire_ff);
      full = (kept_ff == FULL_CNT);

      rd_slot_in = rd_slot_ff;
      wr_slot_in = wr_slot_ff;
      rd_cnt_in  = rd_cnt_ff;
      kept_in    = kept_ff;
      dup_in     = dup_ff;
      oldest_in  = oldest_ff;
      count_in   = count_ff;
      rsp_in     = rsp_ff;

      if (cmd.load) begin
         rd_slot_in = oldest_ff;
         wr_slot_in = oldest_ff;
         rd_cnt_in  = '0;
         kept_in    = '0;
         dup_in     = 1'b0;
      end else begin
         if (cmd.issue) begin
            rd_slot_in = slot_inc(rd_slot_ff);
            rd_cnt_in  = rd_cnt_ff + 1'b1;
         end
         if (keep) begin
            wr_slot_in = slot_inc(wr_slot_ff);
            kept_in    = kept_ff + 1'b1;
            dup_in     = dup_ff | (rd_hash_ff == key_ff);
         end
      end

      if (cmd.commit) begin
         if (dup_ff) begin
            count_in = kept_ff;
         end else if (full) begin
            count_in  = kept_ff;
            oldest_in = slot_inc(oldest_ff);
         end else begin
            count_in = kept_ff + 1'b1;
         end
         rsp_in.is_duplicate   = dup_ff;
         rsp_in.evicted_oldest = !dup_ff && full;
         rsp_in.occupancy      = OCC_WIDTH'(count_in);
      end

      mem_we    = keep || (cmd.commit && !dup_ff);
      mem_whash = cmd.commit ? key_ff : rd_hash_ff;
      mem_wtime = cmd.commit ? now_ff : rd_time_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hash_mem[wr_slot_ff] <= mem_whash;
         time_mem[wr_slot_ff] <= mem_wtime;
      end
      if (cmd.issue) begin
         rd_hash_ff <= hash_mem[rd_slot_ff];
         rd_time_ff <= time_mem[rd_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_word.packet_hash[HASH_BITS-1:0];
         now_ff <= req_word.now_ms;
      end
      rd_slot_ff <= rd_slot_in;
      wr_slot_ff <= wr_slot_in;
      rd_cnt_ff  <= rd_cnt_in;
      kept_ff    <= kept_in;
      dup_ff     <= dup_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expire_ff    <= EXPIRE_RESET;
         oldest_ff    <= '0;
         count_ff     <= '0;
         eval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            expire_ff <= csr_data;
         end
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         eval_ff   <= cmd.issue;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.issue_left = (rd_cnt_ff != count_ff);
   assign status.eval_busy  = eval_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_word          = rsp_ff;

endmodule

`default_nettype wire

/* rtl/flood_packet_dedup_cache_core.sv */
// Top level of the flood packet dedup cache: sequencer plus datapath.
//
// Usage: the req channel (req_valid/req_stall/req_word) takes one word with a
// packet hash and the current millisecond time. The rsp channel
// (rsp_valid/rsp_stall/rsp_word) returns exactly one word per request:
// duplicate flag, eviction flag and occupancy after the update. The csr
// channel (csr_valid/csr_ready/csr_data) writes the expiry limit; csr_ready
// is always high; the user must make writes only while the block is idle, as
// the block itself does not enforce it. One request is processed at a time.
// The sweep reads one held entry per cycle from the single-read-port entry
// memory, compacting survivors and matching the hash; a new request is
// accepted only once the result of the last one has been committed.
// Reset empties the store and loads the expiry limit with 60000 ms. A stalled
// result holds in the output register; the sweep of the next request runs
// meanwhile and its commit waits until the pending result is taken.
`default_nettype none
`include "flood_packet_dedup_cache_core_defines.svh"

module flood_packet_dedup_cache_core #(
   parameter int unsigned DEPTH     = 32,
   parameter int unsigned HASH_BITS = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  fpdc_pkg::req_type  req_word,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output fpdc_pkg::rsp_type  rsp_word,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire [31:0]         csr_data
);
   import fpdc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   fpdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fpdc_datapath #(
      .DEPTH     (DEPTH),
      .HASH_BITS (HASH_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   `FPDC_ASSERT_IMPL(a_commit_after_sweep, clock, reset, cmd.commit, !status.issue_left && !status.eval_busy)
   `FPDC_ASSERT_IMPL(a_rsp_from_commit, clock, reset, $rose(rsp_valid), $past(cmd.commit))
   `FPDC_ASSERT_IMPL(a_evict_not_dup, clock, reset, rsp_valid && rsp_word.evicted_oldest, !rsp_word.is_duplicate)
   `FPDC_ASSERT_NEXT(a_load_then_sweep, clock, reset, cmd.load, !cmd.commit && !cmd.load)

endmodule

`default_nettype wire
